// File: src/mml_pkg.sv
// Package of types, constants and helper functions for the MML token sequencer.
`timescale 1ns / 1ps
package mml_pkg;

    localparam int NumChannelsDef = 16;
    localparam int ChordNotesDef  = 8;
    localparam logic [15:0] TpqReset = 16'd192;

    typedef enum logic [3:0] {
        OP_NOTE   = 4'd0,
        OP_REST   = 4'd1,
        OP_OCTAVE = 4'd2,
        OP_UP     = 4'd3,
        OP_DOWN   = 4'd4,
        OP_LENGTH = 4'd5,
        OP_TEMPO  = 4'd6,
        OP_VOLUME = 4'd7,
        OP_CHAN   = 4'd8,
        OP_CSTART = 4'd9,
        OP_CEND   = 4'd10,
        OP_DOT    = 4'd11,
        OP_TIE    = 4'd12,
        OP_PAN    = 4'd13,
        OP_PROG   = 4'd14,
        OP_EOF    = 4'd15
    } op_t;

    typedef enum logic [2:0] {
        EV_NOTE_ON  = 3'd0,
        EV_NOTE_OFF = 3'd1,
        EV_TEMPO    = 3'd2,
        EV_CC       = 3'd3,
        EV_PROGRAM  = 3'd4,
        EV_END      = 3'd5
    } ev_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_APPLY,
        ST_REL_ON,
        ST_REL_OFF,
        ST_CH_ON,
        ST_CH_OFF,
        ST_CH_ADV,
        ST_EMIT,
        ST_END,
        ST_CLEAR
    } state_t;

    // Request to the shared divider and its answer.
    typedef struct packed {
        logic        start;
        logic [25:0] dividend;
        logic [9:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [25:0] quotient;
    } div_rsp_t;

    localparam logic [25:0] MicrosPerMinute = 26'd60000000;

    // Semitone offset of a note letter; unlisted letters count as C.
    function automatic logic [3:0] semitone(input logic [2:0] letter);
        case (letter)
            3'd1: semitone = 4'd2;
            3'd2: semitone = 4'd4;
            3'd3: semitone = 4'd5;
            3'd4: semitone = 4'd7;
            3'd5: semitone = 4'd9;
            3'd6: semitone = 4'd11;
            default: semitone = 4'd0;
        endcase
    endfunction

    // MIDI velocity for a volume, volume times 127 over 15, truncated.
    function automatic logic [6:0] velocity_of(input logic [9:0] volume);
        logic [3:0] v;
        v = (volume > 10'd15) ? 4'd15 : volume[3:0];
        case (v)
            4'd1:  velocity_of = 7'd8;
            4'd2:  velocity_of = 7'd16;
            4'd3:  velocity_of = 7'd25;
            4'd4:  velocity_of = 7'd33;
            4'd5:  velocity_of = 7'd42;
            4'd6:  velocity_of = 7'd50;
            4'd7:  velocity_of = 7'd59;
            4'd8:  velocity_of = 7'd67;
            4'd9:  velocity_of = 7'd76;
            4'd10: velocity_of = 7'd84;
            4'd11: velocity_of = 7'd93;
            4'd12: velocity_of = 7'd101;
            4'd13: velocity_of = 7'd110;
            4'd14: velocity_of = 7'd118;
            4'd15: velocity_of = 7'd127;
            default: velocity_of = 7'd0;
        endcase
    endfunction

endpackage

// File: src/mml_token_to_midi_events.sv
// MML token sequencer: lexed tokens in, timed MIDI events out.
// A token that divides (note, rest, tempo) waits for the serial divider; other
// tokens go through decode and, for most, apply, plus one output state per event emitted.
// One token is worked at a time; s_ready is low while a token is in progress.
// End of song, and reset, run a clearing pass that restores channel state.
// Synchronous active-low reset clears the control state and sets 192 ticks per quarter.
`timescale 1ns / 1ps
module mml_token_to_midi_events #(
    parameter int NUM_CHANNELS = mml_pkg::NumChannelsDef,
    parameter int CHORD_NOTES  = mml_pkg::ChordNotesDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_op,
    input  logic [9:0]  s_amount,
    input  logic [2:0]  s_note_letter,
    input  logic signed [1:0] s_accidental,
    input  logic [6:0]  s_note_length,
    input  logic        s_dotted,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [3:0]  m_event_channel,
    output logic [31:0] m_event_tick,
    output logic [6:0]  m_key_or_number,
    output logic [6:0]  m_velocity_or_value,
    output logic [21:0] m_tempo_micros,
    output logic        m_last
);
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int NW = (CHORD_NOTES > 1) ? $clog2(CHORD_NOTES) : 1;
    localparam int KW = $clog2(CHORD_NOTES + 1);
    localparam logic [CW:0] ChanLast = (CW+1)'(NUM_CHANNELS - 1);

    // Configuration register.
    logic [15:0] tpq_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) tpq_reg <= mml_pkg::TpqReset;
        else if (cfg_we) tpq_reg <= cfg_wdata;
    end

    // Per-channel state.
    logic [3:0]  oct_reg  [NUM_CHANNELS];
    logic [6:0]  dlen_reg [NUM_CHANNELS];
    logic        ddot_reg [NUM_CHANNELS];
    logic [6:0]  vel_reg  [NUM_CHANNELS];
    logic [31:0] tick_reg [NUM_CHANNELS];
    logic [6:0]  ckey_reg [CHORD_NOTES];
    logic [23:0] cdur_reg [CHORD_NOTES];

    mml_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [31:0] high_reg, high_next;
    logic        pv_reg, pv_next, tie_reg, tie_next;
    logic [6:0]  pkey_reg, pkey_next;
    logic [31:0] pdur_reg, pdur_next;
    logic        inch_reg, inch_next;
    logic [KW-1:0] ccnt_reg, ccnt_next;
    logic [NW:0] idx_reg, idx_next;
    logic [31:0] longest_reg, longest_next;
    logic [CW:0] clr_reg, clr_next;

    // Latched token.
    logic [3:0] op_reg; logic [9:0] amt_reg; logic [2:0] let_reg;
    logic signed [1:0] acc_reg; logic [6:0] len_reg; logic dot_reg;
    logic tok_done_reg, tok_done_next; // token work done after releases

    // Output register.
    logic        ov_reg, ov_next;
    logic [2:0]  okind_reg, okind_next;
    logic [3:0]  och_reg, och_next;
    logic [31:0] otick_reg, otick_next;
    logic [6:0]  okey_reg, okey_next, oval_reg, oval_next;
    logic [21:0] omic_reg, omic_next;
    logic        olast_reg, olast_next;

    // Per-channel write strobes.
    logic        ch_we;
    logic [3:0]  w_oct; logic [6:0] w_dlen; logic w_ddot; logic [6:0] w_vel;
    logic [31:0] w_tick;
    logic        tick_we, chord_we;

    mml_pkg::div_req_t dreq;
    mml_pkg::div_rsp_t drsp;
    mml_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // Derived values for the current token.
    logic [6:0] eff_len; logic eff_dot; logic [9:0] tempo_cl;
    logic [8:0] keyw; logic signed [9:0] keys; logic [6:0] key_cl;
    logic [25:0] dur_dot;
    logic [31:0] cur_tick, rel_dur, adv_tick;
    logic [NW-1:0] ci;
    logic [31:0] cd;
    always_comb begin
        eff_len = (len_reg > 7'd64) ? 7'd64 : len_reg;
        eff_dot = dot_reg;
        if (eff_len == 7'd0) begin
            eff_len = dlen_reg[cur_reg];
            eff_dot = dot_reg | ddot_reg[cur_reg];
        end
        if (eff_len == 7'd0) eff_len = 7'd4;
        tempo_cl = (amt_reg < 10'd20) ? 10'd20 : ((amt_reg > 10'd600) ? 10'd600 : amt_reg);
        keyw = 9'(oct_reg[cur_reg] + 4'd1) * 9'd12;
        keys = $signed({1'b0, keyw}) + $signed({6'd0, mml_pkg::semitone(let_reg)})
             + 10'(acc_reg);
        key_cl = keys[9] ? 7'd0 : ((keys > 10'sd127) ? 7'd127 : keys[6:0]);
        dur_dot = eff_dot ? 26'((27'(drsp.quotient) * 27'd3) >> 1) : drsp.quotient;
        cur_tick = tick_reg[cur_reg];
        ci = idx_reg[NW-1:0];
        cd = {8'd0, cdur_reg[ci]};
        rel_dur = pdur_reg;
        adv_tick = cur_tick + pdur_reg;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg; cur_next = cur_reg; high_next = high_reg;
        pv_next = pv_reg; tie_next = tie_reg; pkey_next = pkey_reg; pdur_next = pdur_reg;
        inch_next = inch_reg; ccnt_next = ccnt_reg; idx_next = idx_reg;
        longest_next = longest_reg; clr_next = clr_reg; tok_done_next = tok_done_reg;
        ov_next = ov_reg; okind_next = okind_reg; och_next = och_reg;
        otick_next = otick_reg; okey_next = okey_reg; oval_next = oval_reg;
        omic_next = omic_reg; olast_next = olast_reg;
        ch_we = 1'b0; w_oct = oct_reg[cur_reg]; w_dlen = dlen_reg[cur_reg];
        w_ddot = ddot_reg[cur_reg]; w_vel = vel_reg[cur_reg];
        tick_we = 1'b0; w_tick = cur_tick; chord_we = 1'b0;
        dreq.start = 1'b0; dreq.dividend = {8'd0, tpq_reg, 2'b00};
        dreq.divisor = {3'd0, eff_len};
        s_ready = 1'b0;
        if (ov_reg && m_ready) ov_next = 1'b0;

        case (state_reg)
            mml_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = mml_pkg::ST_DECODE;
            end
            mml_pkg::ST_DECODE: begin
                tok_done_next = 1'b0;
                if (inch_reg) begin
                    if (op_reg == mml_pkg::OP_NOTE) begin
                        if (32'(ccnt_reg) < 32'(CHORD_NOTES)) begin
                            dreq.start = 1'b1;
                            state_next = mml_pkg::ST_DIV;
                        end else state_next = mml_pkg::ST_IDLE;
                    end else if (op_reg == mml_pkg::OP_CEND || op_reg == mml_pkg::OP_EOF) begin
                        idx_next = '0; longest_next = '0;
                        state_next = mml_pkg::ST_CH_ON;
                    end else state_next = mml_pkg::ST_IDLE;
                end else if (pv_reg && op_reg == mml_pkg::OP_TIE) begin
                    tie_next = 1'b1; state_next = mml_pkg::ST_IDLE;
                end else if (pv_reg && !(op_reg == mml_pkg::OP_NOTE && tie_reg)) begin
                    state_next = mml_pkg::ST_REL_ON;
                end else begin
                    state_next = mml_pkg::ST_APPLY;
                end
                if (state_next == mml_pkg::ST_APPLY &&
                    (op_reg == mml_pkg::OP_NOTE || op_reg == mml_pkg::OP_REST)) begin
                    dreq.start = 1'b1; state_next = mml_pkg::ST_DIV;
                end
                if (state_next == mml_pkg::ST_APPLY && op_reg == mml_pkg::OP_TEMPO) begin
                    dreq.start = 1'b1; dreq.dividend = mml_pkg::MicrosPerMinute;
                    dreq.divisor = tempo_cl; state_next = mml_pkg::ST_DIV;
                end
            end
            mml_pkg::ST_DIV: begin
                if (drsp.done) begin
                    if (inch_reg) begin
                        chord_we = 1'b1; ccnt_next = ccnt_reg + 1'b1;
                        state_next = mml_pkg::ST_IDLE;
                    end else if (op_reg == mml_pkg::OP_TEMPO) begin
                        state_next = mml_pkg::ST_EMIT;
                    end else if (op_reg == mml_pkg::OP_REST) begin
                        tick_we = 1'b1; w_tick = cur_tick + 32'(dur_dot);
                        if (w_tick > high_reg) high_next = w_tick;
                        state_next = mml_pkg::ST_IDLE;
                    end else if (pv_reg) begin
                        pdur_next = pdur_reg + 32'(dur_dot); tie_next = 1'b0;
                        state_next = mml_pkg::ST_IDLE;
                    end else begin
                        pv_next = 1'b1; tie_next = 1'b0; pkey_next = key_cl;
                        pdur_next = 32'(dur_dot); state_next = mml_pkg::ST_IDLE;
                    end
                end
            end
            mml_pkg::ST_REL_ON: begin
                if (!ov_next) begin
                    ov_next = 1'b1; okind_next = mml_pkg::EV_NOTE_ON;
                    och_next = 4'(cur_reg); otick_next = cur_tick; okey_next = pkey_reg;
                    oval_next = vel_reg[cur_reg]; omic_next = '0; olast_next = 1'b0;
                    state_next = mml_pkg::ST_REL_OFF;
                end
            end
            mml_pkg::ST_REL_OFF: begin
                if (!ov_next) begin
                    ov_next = 1'b1; okind_next = mml_pkg::EV_NOTE_OFF;
                    otick_next = (rel_dur == 0) ? cur_tick : adv_tick - 32'd1;
                    oval_next = '0;
                    olast_next = !(op_reg == mml_pkg::OP_TEMPO || op_reg == mml_pkg::OP_PAN
                                 || op_reg == mml_pkg::OP_PROG || op_reg == mml_pkg::OP_EOF);
                    tick_we = 1'b1; w_tick = adv_tick;
                    if (adv_tick > high_reg) high_next = adv_tick;
                    pv_next = 1'b0; tie_next = 1'b0;
                    state_next = mml_pkg::ST_APPLY;
                    if (op_reg == mml_pkg::OP_NOTE || op_reg == mml_pkg::OP_REST) begin
                        dreq.start = 1'b1; state_next = mml_pkg::ST_DIV;
                    end
                    if (op_reg == mml_pkg::OP_TEMPO) begin
                        dreq.start = 1'b1; dreq.dividend = mml_pkg::MicrosPerMinute;
                        dreq.divisor = tempo_cl; state_next = mml_pkg::ST_DIV;
                    end
                end
            end
            mml_pkg::ST_CH_ON: begin
                if (idx_reg >= (NW+1)'(ccnt_reg)) begin
                    state_next = mml_pkg::ST_CH_ADV;
                end else if (!ov_next) begin
                    ov_next = 1'b1; okind_next = mml_pkg::EV_NOTE_ON;
                    och_next = 4'(cur_reg); otick_next = cur_tick; okey_next = ckey_reg[ci];
                    oval_next = vel_reg[cur_reg]; omic_next = '0; olast_next = 1'b0;
                    if (cd > longest_reg) longest_next = cd;
                    state_next = mml_pkg::ST_CH_OFF;
                end
            end
            mml_pkg::ST_CH_OFF: begin
                if (!ov_next) begin
                    ov_next = 1'b1; okind_next = mml_pkg::EV_NOTE_OFF;
                    otick_next = (cd == 0) ? cur_tick : cur_tick + cd - 32'd1;
                    oval_next = '0;
                    olast_next = (idx_reg + 1'b1 == (NW+1)'(ccnt_reg))
                                 && op_reg != mml_pkg::OP_EOF;
                    idx_next = idx_reg + 1'b1;
                    state_next = mml_pkg::ST_CH_ON;
                end
            end
            mml_pkg::ST_CH_ADV: begin
                tick_we = 1'b1; w_tick = cur_tick + longest_reg;
                if (w_tick > high_reg) high_next = w_tick;
                inch_next = 1'b0; ccnt_next = '0;
                state_next = (op_reg == mml_pkg::OP_EOF) ? mml_pkg::ST_END
                                                         : mml_pkg::ST_IDLE;
            end
            mml_pkg::ST_APPLY: begin
                state_next = mml_pkg::ST_IDLE;
                ch_we = 1'b1;
                case (op_reg)
                    mml_pkg::OP_OCTAVE: w_oct = (amt_reg > 10'd8) ? 4'd8 : amt_reg[3:0];
                    mml_pkg::OP_UP:   if (w_oct < 4'd8) w_oct = w_oct + 4'd1;
                    mml_pkg::OP_DOWN: if (w_oct > 4'd0) w_oct = w_oct - 4'd1;
                    mml_pkg::OP_LENGTH: begin
                        w_dlen = (amt_reg == 0) ? 7'd1 : ((amt_reg > 10'd64) ? 7'd64
                                                                : amt_reg[6:0]);
                        w_ddot = dot_reg;
                    end
                    mml_pkg::OP_VOLUME: w_vel = mml_pkg::velocity_of(amt_reg);
                    mml_pkg::OP_CHAN: begin
                        if (amt_reg == 0) cur_next = '0;
                        else if (amt_reg > 10'(NUM_CHANNELS)) cur_next = ChanLast[CW-1:0];
                        else cur_next = CW'(amt_reg - 10'd1);
                    end
                    mml_pkg::OP_CSTART: begin inch_next = 1'b1; ccnt_next = '0; end
                    mml_pkg::OP_PAN, mml_pkg::OP_PROG: state_next = mml_pkg::ST_EMIT;
                    mml_pkg::OP_EOF: state_next = mml_pkg::ST_END;
                    default: ;
                endcase
            end
            mml_pkg::ST_EMIT: begin
                if (!ov_next) begin
                    ov_next = 1'b1; och_next = 4'(cur_reg); otick_next = cur_tick;
                    okey_next = '0; oval_next = '0; omic_next = '0; olast_next = 1'b1;
                    if (op_reg == mml_pkg::OP_TEMPO) begin
                        okind_next = mml_pkg::EV_TEMPO; och_next = '0;
                        omic_next = drsp.quotient[21:0];
                    end else if (op_reg == mml_pkg::OP_PAN) begin
                        okind_next = mml_pkg::EV_CC; okey_next = 7'd10;
                        oval_next = (amt_reg > 10'd127) ? 7'd127 : amt_reg[6:0];
                    end else begin
                        okind_next = mml_pkg::EV_PROGRAM;
                        okey_next = (amt_reg > 10'd127) ? 7'd127 : amt_reg[6:0];
                    end
                    state_next = mml_pkg::ST_IDLE;
                end
            end
            mml_pkg::ST_END: begin
                if (!ov_next) begin
                    ov_next = 1'b1; okind_next = mml_pkg::EV_END; och_next = '0;
                    otick_next = high_reg; okey_next = '0; oval_next = '0;
                    omic_next = '0; olast_next = 1'b1;
                    clr_next = '0; state_next = mml_pkg::ST_CLEAR;
                end
            end
            mml_pkg::ST_CLEAR: begin
                cur_next = clr_reg[CW-1:0];
                if (clr_reg == ChanLast) state_next = mml_pkg::ST_IDLE;
                clr_next = clr_reg + 1'b1;
                high_next = '0; pv_next = 1'b0; tie_next = 1'b0; pkey_next = '0;
                pdur_next = '0; inch_next = 1'b0; ccnt_next = '0;
                if (clr_reg == ChanLast) cur_next = '0;
            end
            default: state_next = mml_pkg::ST_IDLE;
        endcase
        if (tok_done_reg) tok_done_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mml_pkg::ST_CLEAR; clr_reg <= '0; cur_reg <= '0;
            high_reg <= '0; pv_reg <= 1'b0; tie_reg <= 1'b0; inch_reg <= 1'b0;
            ccnt_reg <= '0; idx_reg <= '0; ov_reg <= 1'b0; tok_done_reg <= 1'b0;
            pkey_reg <= '0; pdur_reg <= '0; longest_reg <= '0;
        end else begin
            state_reg <= state_next; clr_reg <= clr_next; cur_reg <= cur_next;
            high_reg <= high_next; pv_reg <= pv_next; tie_reg <= tie_next;
            inch_reg <= inch_next; ccnt_reg <= ccnt_next; idx_reg <= idx_next;
            ov_reg <= ov_next; tok_done_reg <= tok_done_next;
            pkey_reg <= pkey_next; pdur_reg <= pdur_next; longest_reg <= longest_next;
        end
        okind_reg <= okind_next; och_reg <= och_next; otick_reg <= otick_next;
        okey_reg <= okey_next; oval_reg <= oval_next; omic_reg <= omic_next;
        olast_reg <= olast_next;
        if (s_valid && s_ready) begin
            op_reg <= s_op; amt_reg <= s_amount; let_reg <= s_note_letter;
            acc_reg <= s_accidental; len_reg <= s_note_length; dot_reg <= s_dotted;
        end
    end

    // Channel and chord storage; the clearing pass restores one channel a cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == mml_pkg::ST_CLEAR) begin
            oct_reg[clr_reg[CW-1:0]]  <= 4'd4;
            dlen_reg[clr_reg[CW-1:0]] <= 7'd4;
            ddot_reg[clr_reg[CW-1:0]] <= 1'b0;
            vel_reg[clr_reg[CW-1:0]]  <= 7'd100;
            tick_reg[clr_reg[CW-1:0]] <= '0;
        end else begin
            if (ch_we) begin
                oct_reg[cur_reg] <= w_oct; dlen_reg[cur_reg] <= w_dlen;
                ddot_reg[cur_reg] <= w_ddot; vel_reg[cur_reg] <= w_vel;
            end
            if (tick_we) tick_reg[cur_reg] <= w_tick;
        end
        if (chord_we) begin
            ckey_reg[ccnt_reg[NW-1:0]] <= key_cl;
            cdur_reg[ccnt_reg[NW-1:0]] <= dur_dot[23:0];
        end
    end

    assign m_valid = ov_reg;
    assign m_event_kind = okind_reg;
    assign m_event_channel = och_reg;
    assign m_event_tick = otick_reg;
    assign m_key_or_number = okey_reg;
    assign m_velocity_or_value = oval_reg;
    assign m_tempo_micros = omic_reg;
    assign m_last = olast_reg;
endmodule

// File: src/mml_divider.sv
// Restoring divider, one quotient bit per cycle, shared by durations and tempo.
`timescale 1ns / 1ps
module mml_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  mml_pkg::div_req_t   req,
    output mml_pkg::div_rsp_t   rsp
);
    logic [25:0] quot_reg, quot_next;
    logic [9:0]  rem_reg, rem_next;
    logic [9:0]  dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [10:0] trial;

    // One shift and subtract step per cycle.
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[25]} - {1'b0, dsr_reg};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 5'd25;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[10]) begin
                rem_next = trial[9:0];
            end else begin
                rem_next = {rem_reg[8:0], quot_reg[25]};
            end
            quot_next = {quot_reg[24:0], ~trial[10]};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the MML token sequencer with its own event predictor.
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  chan;
        logic [31:0] tick;
        logic [6:0]  key;
        logic [6:0]  val;
        logic [21:0] micros;
        logic        last;
    } midi_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_op = '0;
    logic [9:0]  s_amount = '0;
    logic [2:0]  s_note_letter = '0;
    logic signed [1:0] s_accidental = '0;
    logic [6:0]  s_note_length = '0;
    logic        s_dotted = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_kind;
    logic [3:0]  m_event_channel;
    logic [31:0] m_event_tick;
    logic [6:0]  m_key_or_number;
    logic [6:0]  m_velocity_or_value;
    logic [21:0] m_tempo_micros;
    logic        m_last;

    mml_token_to_midi_events dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_amount(s_amount),
        .s_note_letter(s_note_letter), .s_accidental(s_accidental),
        .s_note_length(s_note_length), .s_dotted(s_dotted),
        .m_valid(m_valid), .m_ready(m_ready), .m_event_kind(m_event_kind),
        .m_event_channel(m_event_channel), .m_event_tick(m_event_tick),
        .m_key_or_number(m_key_or_number), .m_velocity_or_value(m_velocity_or_value),
        .m_tempo_micros(m_tempo_micros), .m_last(m_last)
    );

    always #4 aclk = ~aclk;

    // Predicted sequencer state.
    logic [15:0] tpq;
    logic [3:0]  octave_of [16];
    logic [6:0]  deflen_of [16];
    logic        defdot_of [16];
    logic [6:0]  vel_of [16];
    logic [31:0] tick_of [16];
    logic [3:0]  cur_chan;
    logic [31:0] song_end_tick;
    logic        held_valid, held_tied;
    logic [6:0]  held_key;
    logic [31:0] held_dur;
    logic        chord_open;
    int          chord_n;
    logic [6:0]  chord_keys [8];
    logic [31:0] chord_durs [8];
    const int    semis [8] = '{0, 2, 4, 5, 7, 9, 11, 0};

    midi_event_t pending_events [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          no_stall = 1'b0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic void clear_song();
        for (int i = 0; i < 16; i++) begin
            octave_of[i] = 4; deflen_of[i] = 4; defdot_of[i] = 0;
            vel_of[i] = 100; tick_of[i] = 0;
        end
        cur_chan = 0; song_end_tick = 0;
        held_valid = 0; held_tied = 0; held_key = 0; held_dur = 0;
        chord_open = 0; chord_n = 0;
    endfunction

    function automatic void push_event(input logic [2:0] k, input logic [3:0] c,
                                       input logic [31:0] t, input logic [6:0] key,
                                       input logic [6:0] v, input logic [21:0] us);
        midi_event_t e;
        e.kind = k; e.chan = c; e.tick = t; e.key = key; e.val = v; e.micros = us;
        e.last = 0;
        pending_events.push_back(e);
    endfunction

    function automatic logic [31:0] ticks_for(input logic [6:0] len_in, input logic dot_in);
        int unsigned l;
        logic d;
        logic [31:0] t;
        l = len_in > 64 ? 64 : len_in;
        d = dot_in;
        if (l == 0) begin
            l = deflen_of[cur_chan];
            d = d | defdot_of[cur_chan];
        end
        if (l == 0) l = 4;
        t = (32'(tpq) * 4) / l;
        if (d) t = (t * 3) / 2;
        return t;
    endfunction

    function automatic logic [6:0] key_for(input logic [2:0] letter, input logic signed [1:0] acc);
        int k;
        k = 12 * (int'(octave_of[cur_chan]) + 1) + semis[letter] + int'(acc);
        if (k < 0) k = 0;
        if (k > 127) k = 127;
        return 7'(k);
    endfunction

    function automatic void play(input logic [6:0] key, input logic [31:0] dur);
        logic [31:0] st;
        st = tick_of[cur_chan];
        push_event(mml_pkg::EV_NOTE_ON, cur_chan, st, key, vel_of[cur_chan], 0);
        push_event(mml_pkg::EV_NOTE_OFF, cur_chan, dur == 0 ? st : st + dur - 1, key, 0, 0);
    endfunction

    function automatic void move_tick(input logic [31:0] d);
        tick_of[cur_chan] += d;
        if (tick_of[cur_chan] > song_end_tick) song_end_tick = tick_of[cur_chan];
    endfunction

    function automatic void flush_chord();
        logic [31:0] longest;
        longest = 0;
        for (int i = 0; i < chord_n; i++) begin
            if (chord_durs[i] > longest) longest = chord_durs[i];
            play(chord_keys[i], chord_durs[i]);
        end
        move_tick(longest);
        chord_open = 0; chord_n = 0;
    endfunction

    function automatic int unsigned clip(input int unsigned v, lo, hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Works out the events caused by one token.
    function automatic void predict_events(input mml_pkg::op_t op, input logic [9:0] amt,
                                           input logic [2:0] letter,
                                           input logic signed [1:0] acc,
                                           input logic [6:0] len, input logic dot);
        int prior_count;
        logic [3:0] c;
        prior_count = pending_events.size();
        if (chord_open) begin
            if (op == mml_pkg::OP_NOTE) begin
                if (chord_n < 8) begin
                    chord_keys[chord_n] = key_for(letter, acc);
                    chord_durs[chord_n] = ticks_for(len, dot);
                    chord_n++;
                end
            end else if (op == mml_pkg::OP_CEND) begin
                flush_chord();
            end else if (op == mml_pkg::OP_EOF) begin
                flush_chord();
                push_event(mml_pkg::EV_END, 0, song_end_tick, 0, 0, 0);
                clear_song();
            end
        end else begin
            if (held_valid && op == mml_pkg::OP_TIE) begin
                held_tied = 1;
                return;
            end
            if (held_valid && op == mml_pkg::OP_NOTE && held_tied) begin
                held_dur += ticks_for(len, dot);
                held_tied = 0;
                return;
            end
            if (held_valid) begin
                play(held_key, held_dur);
                move_tick(held_dur);
                held_valid = 0; held_tied = 0;
            end
            c = cur_chan;
            case (op)
                mml_pkg::OP_NOTE: begin
                    held_valid = 1; held_tied = 0;
                    held_key = key_for(letter, acc);
                    held_dur = ticks_for(len, dot);
                end
                mml_pkg::OP_REST: move_tick(ticks_for(len, dot));
                mml_pkg::OP_OCTAVE: octave_of[c] = clip(amt, 0, 8);
                mml_pkg::OP_UP: if (octave_of[c] < 8) octave_of[c]++;
                mml_pkg::OP_DOWN: if (octave_of[c] > 0) octave_of[c]--;
                mml_pkg::OP_LENGTH: begin
                    deflen_of[c] = clip(amt, 1, 64);
                    defdot_of[c] = dot;
                end
                mml_pkg::OP_TEMPO: push_event(mml_pkg::EV_TEMPO, 0, tick_of[c], 0, 0,
                                              22'(60000000 / clip(amt, 20, 600)));
                mml_pkg::OP_VOLUME: vel_of[c] = 7'((clip(amt, 0, 15) * 127) / 15);
                mml_pkg::OP_CHAN: cur_chan = 4'(clip(amt, 1, 16) - 1);
                mml_pkg::OP_CSTART: begin
                    chord_open = 1; chord_n = 0;
                end
                mml_pkg::OP_PAN: push_event(mml_pkg::EV_CC, c, tick_of[c], 10,
                                            7'(clip(amt, 0, 127)), 0);
                mml_pkg::OP_PROG: push_event(mml_pkg::EV_PROGRAM, c, tick_of[c],
                                             7'(clip(amt, 0, 127)), 0, 0);
                mml_pkg::OP_EOF: begin
                    push_event(mml_pkg::EV_END, 0, song_end_tick, 0, 0, 0);
                    clear_song();
                end
                default: ;
            endcase
        end
        if (pending_events.size() > prior_count) pending_events[$].last = 1;
    endfunction

    // Sends one item after a random gap and predicts its events on acceptance.
    task automatic send_token(input mml_pkg::op_t op, input int amt = 0, input int letter = 0,
                              input int acc = 0, input int len = 0, input bit dot = 0);
        repeat ($urandom_range(0, no_stall ? 0 : 4)) @(negedge aclk);
        s_op = op; s_amount = 10'(amt); s_note_letter = 3'(letter);
        s_accidental = 2'(acc); s_note_length = 7'(len); s_dotted = dot;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_events(mml_pkg::op_t'(s_op), s_amount, s_note_letter, s_accidental,
                       s_note_length, s_dotted);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Waits until every expected event has arrived and the block is idle, then writes tpq.
    task automatic set_tpq(input logic [15:0] value);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        @(negedge aclk);
        cfg_we = 1'b1; cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        tpq = value;
    endtask

    // Result checker with a random stall before each event.
    initial begin
        midi_event_t e;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready = 1'b0;
            repeat ($urandom_range(0, no_stall ? 0 : 4)) @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_events.size() == 0) begin
                report($sformatf("unexpected event kind %0d tick %0d", m_event_kind,
                                 m_event_tick));
            end else begin
                e = pending_events.pop_front();
                if (m_event_kind !== e.kind)
                    report($sformatf("kind %0d, want %0d", m_event_kind, e.kind));
                if (m_event_channel !== e.chan)
                    report($sformatf("channel %0d, want %0d", m_event_channel, e.chan));
                if (m_event_tick !== e.tick)
                    report($sformatf("tick %0d, want %0d", m_event_tick, e.tick));
                if (m_key_or_number !== e.key)
                    report($sformatf("key %0d, want %0d", m_key_or_number, e.key));
                if (m_velocity_or_value !== e.val)
                    report($sformatf("value %0d, want %0d", m_velocity_or_value, e.val));
                if (m_tempo_micros !== e.micros)
                    report($sformatf("micros %0d, want %0d", m_tempo_micros, e.micros));
                if (m_last !== e.last)
                    report($sformatf("last %0d, want %0d", m_last, e.last));
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == 20000) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Field extremes, every token kind but chord start, and the odd encodings.
    task automatic test_basic_tokens();
        send_token(mml_pkg::OP_TEMPO, 0);
        send_token(mml_pkg::OP_TEMPO, 1023);
        send_token(mml_pkg::OP_TEMPO, 120);
        send_token(mml_pkg::OP_CHAN, 16);
        send_token(mml_pkg::OP_OCTAVE, 1023);
        send_token(mml_pkg::OP_UP);
        send_token(mml_pkg::OP_NOTE, 0, 6, 1, 127, 1);
        send_token(mml_pkg::OP_VOLUME, 1023);
        send_token(mml_pkg::OP_PAN, 1023);
        send_token(mml_pkg::OP_PROG, 127);
        send_token(mml_pkg::OP_OCTAVE, 0);
        send_token(mml_pkg::OP_DOWN);
        send_token(mml_pkg::OP_NOTE, 0, 7, -2, 0, 0);
        send_token(mml_pkg::OP_LENGTH, 0, 0, 0, 0, 1);
        send_token(mml_pkg::OP_REST, 0);
        send_token(mml_pkg::OP_LENGTH, 1023, 0, 0, 0, 0);
        send_token(mml_pkg::OP_NOTE, 1023, 3, -1, 1, 0);
        send_token(mml_pkg::OP_DOT);
        send_token(mml_pkg::OP_CEND);
        send_token(mml_pkg::OP_TIE);
        send_token(mml_pkg::OP_CHAN, 0);
        send_token(mml_pkg::OP_VOLUME, 0);
        send_token(mml_pkg::OP_NOTE, 0, 2, 0, 8, 0);
        send_token(mml_pkg::OP_EOF);
    endtask

    // Ties: armed, chained, and broken by other tokens.
    task automatic test_ties();
        send_token(mml_pkg::OP_NOTE, 0, 4, 0, 4, 0);
        send_token(mml_pkg::OP_TIE);
        send_token(mml_pkg::OP_TIE);
        send_token(mml_pkg::OP_NOTE, 0, 1, 1, 8, 1);
        send_token(mml_pkg::OP_TIE);
        send_token(mml_pkg::OP_NOTE, 0, 0, 0, 16, 0);
        send_token(mml_pkg::OP_NOTE, 0, 5, 0, 2, 0);
        send_token(mml_pkg::OP_TIE);
        send_token(mml_pkg::OP_PAN, 64);
        send_token(mml_pkg::OP_EOF);
    endtask

    // Chords: overflow past eight notes, empty chord, ignored tokens inside.
    task automatic test_chords();
        send_token(mml_pkg::OP_CSTART);
        for (int i = 0; i < 10; i++)
            send_token(mml_pkg::OP_NOTE, 0, i % 7, 0, 1 << (i % 7), 0);
        send_token(mml_pkg::OP_TEMPO, 200);
        send_token(mml_pkg::OP_CEND);
        send_token(mml_pkg::OP_CSTART);
        send_token(mml_pkg::OP_CEND);
        send_token(mml_pkg::OP_NOTE, 0, 0, 0, 4, 0);
        send_token(mml_pkg::OP_CSTART);
        send_token(mml_pkg::OP_NOTE, 0, 2, 0, 4, 1);
        send_token(mml_pkg::OP_EOF);
    endtask

    // Zero-length notes when ticks per quarter is tiny.
    task automatic test_zero_duration();
        send_token(mml_pkg::OP_NOTE, 0, 0, 0, 64, 0);
        send_token(mml_pkg::OP_REST, 0, 0, 0, 64, 1);
        send_token(mml_pkg::OP_NOTE, 0, 1, 0, 1, 1);
        send_token(mml_pkg::OP_EOF);
    endtask

    // Mostly well-formed phrases with random content, plus random noise tokens.
    task automatic test_random(input int count);
        int sent, sel, n;
        sent = 0;
        while (sent < count) begin
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
                send_token(mml_pkg::OP_NOTE, $urandom, $urandom, $urandom,
                           $urandom_range(0, 127), $urandom);
                if ($urandom_range(0, 1)) begin
                    send_token(mml_pkg::OP_TIE);
                    send_token(mml_pkg::OP_NOTE, $urandom, $urandom, $urandom,
                               $urandom_range(0, 127), $urandom);
                    sent += 2;
                end
                sent++;
            end else if (sel < 5) begin
                send_token(mml_pkg::OP_CSTART);
                n = $urandom_range(0, 9);
                repeat (n)
                    send_token(mml_pkg::op_t'(4'($urandom_range(0, 3) == 0 ?
                                                  $urandom_range(1, 14) : 0)),
                               $urandom, $urandom, $urandom, $urandom_range(0, 127),
                               $urandom);
                send_token($urandom_range(0, 7) == 0 ? mml_pkg::OP_EOF : mml_pkg::OP_CEND);
                sent += n + 2;
            end else begin
                send_token(mml_pkg::op_t'(4'($urandom)), $urandom, $urandom, $urandom,
                           $urandom_range(0, 127), $urandom);
                sent++;
            end
        end
        send_token(mml_pkg::OP_EOF);
    endtask

    initial begin
        tpq = mml_pkg::TpqReset;
        clear_song();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (40) @(posedge aclk);
        @(negedge aclk);
        test_basic_tokens();
        no_stall = 1'b1;
        test_ties();
        no_stall = 1'b0;
        set_tpq(16'd65535);
        test_chords();
        test_ties();
        set_tpq(16'd8);
        test_zero_duration();
        set_tpq(16'd16);
        test_random(20);
        set_tpq(16'($urandom_range(16, 65535)));
        test_random(30);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
